// ===== rtl/core/s256id_pkg.sv =====
`timescale 1ns / 1ps
package s256id_pkg;

    localparam int QUEUE_DEPTH = 4;

    // queued item: byte plus flags
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       last;
    } item_t;

    localparam logic [31:0] INIT_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // lower-case ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        hex_char = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});
    endfunction

endpackage

// ===== rtl/core/s256id_front.sv =====
`timescale 1ns / 1ps
module s256id_front
    import s256id_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] msg_byte,
    input  logic       has_byte,
    input  logic       last,
    output logic       ready,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_ready
);

    localparam int AW = $clog2(DEPTH);

    item_t             mem [DEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;
    logic              push, pop;

    // items with neither byte nor end are dropped here
    assign ready   = (cnt_reg != DEPTH[AW:0]);
    assign push    = ready && (has_byte || last);
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= '{msg_byte: msg_byte, has_byte: has_byte, last: last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// ===== rtl/core/s256id_back.sv =====
`timescale 1ns / 1ps
module s256id_back
    import s256id_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] id_text,
    output logic [23:0] id_value
);

    typedef enum logic [4:0] {
        S_COLLECT = 5'b00001,
        S_PAD     = 5'b00010,
        S_ROUND   = 5'b00100,
        S_FINAL   = 5'b01000,
        S_WAIT    = 5'b10000
    } state_t;

    state_t       state_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [31:0]  count_reg;
    logic [5:0]   pos_reg;
    logic [5:0]   rnd_reg;
    logic         ending_reg;
    logic         mark_reg;
    logic         len_ok_reg;

    logic [31:0]  w_new, s0, s1, t1, t2;
    logic [31:0]  h0_sum;
    logic [63:0]  bits;
    logic [7:0]   pad_b;
    logic         fin_done;

    assign bits     = {29'd0, count_reg, 3'd0};
    assign h0_sum   = h_reg[0] + v_reg[0];
    // length block just compressed: message is complete
    assign fin_done = ending_reg && !mark_reg && len_ok_reg;

    // schedule: window slides each round, slot 0 is current word
    always_comb
    begin
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        t1 = v_reg[7] + (rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6])) + ROUND_K[rnd_reg]
             + w_reg[0];
        t2 = (rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    // padding byte for current slot: end marker, zeros, then bit length
    always_comb
    begin
        if (mark_reg)
        begin
            pad_b = PAD_BYTE;
        end
        else if (pos_reg[5:3] == 3'b111 && len_ok_reg)
        begin
            pad_b = bits[{~pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_b = 8'h00;
        end
    end

    assign q_ready   = (state_reg == S_COLLECT);
    assign out_valid = (state_reg == S_WAIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_COLLECT;
            count_reg  <= '0;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            ending_reg <= 1'b0;
            mark_reg   <= 1'b0;
            len_ok_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_WORDS[i];
            end
        end
        else
        begin
            unique case (state_reg)
                S_COLLECT:
                begin
                    if (q_valid)
                    begin
                        if (q_item.has_byte)
                        begin
                            count_reg <= count_reg + 32'd1;
                            pos_reg   <= pos_reg + 6'd1;
                        end
                        if (q_item.last)
                        begin
                            ending_reg <= 1'b1;
                            mark_reg   <= 1'b1;
                        end
                        if (q_item.has_byte && pos_reg == 6'd63)
                        begin
                            state_reg <= S_ROUND;
                        end
                        else if (q_item.last)
                        begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    // marker decides whether the length fits in this block
                    pos_reg <= pos_reg + 6'd1;
                    if (mark_reg)
                    begin
                        mark_reg   <= 1'b0;
                        len_ok_reg <= (pos_reg < 6'd56);
                    end
                    if (pos_reg == 6'd63)
                    begin
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63)
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (fin_done)
                    begin
                        state_reg <= S_WAIT;
                    end
                    else if (ending_reg)
                    begin
                        // another padding block carries the length
                        len_ok_reg <= 1'b1;
                        state_reg  <= S_PAD;
                    end
                    else
                    begin
                        state_reg <= S_COLLECT;
                    end
                end
                S_WAIT:
                begin
                    if (out_ready)
                    begin
                        state_reg  <= S_COLLECT;
                        count_reg  <= '0;
                        ending_reg <= 1'b0;
                        len_ok_reg <= 1'b0;
                        for (int i = 0; i < 8; i++)
                        begin
                            h_reg[i] <= INIT_WORDS[i];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_COLLECT;
                end
            endcase
        end
    end

    // schedule window: bytes packed big-endian, then slid per round
    always_ff @(posedge clk)
    begin
        if (state_reg == S_COLLECT && q_valid && q_item.has_byte)
        begin
            w_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= q_item.msg_byte;
        end
        else if (state_reg == S_PAD)
        begin
            w_reg[pos_reg[5:2]][{~pos_reg[1:0], 3'b000} +: 8] <= pad_b;
        end
        else if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
    end

    // working variables: loaded from chain outside rounds
    always_ff @(posedge clk)
    begin
        if (state_reg != S_ROUND)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINAL && fin_done)
        begin
            id_value <= h0_sum[31:8];
            for (int i = 0; i < 6; i++)
            begin
                id_text[47-8*i -: 8] <= hex_char(h0_sum[31-4*i -: 4]);
            end
        end
    end

endmodule

// ===== rtl/core/sha256_short_hex_id_unit.sv =====
`timescale 1ns / 1ps
// Short SHA-256 identifier. Items enter through a queue of DEPTH entries that
// accepts one item per cycle while it has room; items with neither a byte nor
// the last flag are dropped there. The engine takes one byte per cycle and,
// after each 64th byte, stalls for the 64 rounds and the final add. After a
// last item it writes the padding bytes (one per cycle up to the end of the
// block) and compresses one or two more blocks, depending on whether the
// length fits in the current block, until the 24-bit value and the six hex
// characters appear. The result is held until taken; meanwhile no further
// bytes are consumed.
module sha256_short_hex_id_unit
    import s256id_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [47:0] id_text,
    output logic [23:0] id_value
);

    logic  q_valid, q_ready, f_ready;
    item_t q_item;

    assign ready = f_ready;

    s256id_front #(.DEPTH(DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .msg_byte(msg_byte), .has_byte(has_byte & valid), .last(last & valid),
        .ready(f_ready), .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
    );

    s256id_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .id_text(id_text), .id_value(id_value)
    );

endmodule

// ===== rtl/core/s256id_checker.sv =====
`timescale 1ns / 1ps
module s256id_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [47:0] id_text,
    input logic [23:0] id_value
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(id_value))
        else $error("result dropped while stalled");

    a_hex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> id_text[47:44] == 4'h3 || id_text[47:44] == 4'h6)
        else $error("bad hex character");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");

endmodule

bind sha256_short_hex_id_unit s256id_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .id_text(id_text), .id_value(id_value)
);
